// ===== design/abt_pkg.sv =====
// Shared types, register codes and helpers of the drive bias transfer block.
package abt_pkg;

	// Register indexes on the write port
	localparam logic [2:0] CFG_BASE_BIAS  = 3'd0;
	localparam logic [2:0] CFG_BIAS_MAX   = 3'd1;
	localparam logic [2:0] CFG_TL_MIN     = 3'd2;
	localparam logic [2:0] CFG_TL_MAX     = 3'd3;
	localparam logic [2:0] CFG_OS_WINDOW  = 3'd4;
	localparam logic [2:0] CFG_US_WINDOW  = 3'd5;
	localparam logic [2:0] CFG_ENABLES    = 3'd6;

	// Result source codes
	localparam logic [2:0] SRC_NONE     = 3'd0;
	localparam logic [2:0] SRC_TR_REAR  = 3'd1;
	localparam logic [2:0] SRC_TR_FRONT = 3'd2;
	localparam logic [2:0] SRC_OVER     = 3'd3;
	localparam logic [2:0] SRC_UNDER    = 3'd4;

	// How a ratio is formed in the divider
	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_FIX  = 2'd1;
	localparam logic [1:0] KIND_DIV  = 2'd2;

	localparam logic [12:0] Q12_ONE  = 13'd4096;
	localparam logic [12:0] Q12_HALF = 13'd2048;

	typedef struct packed {
		logic [12:0] base_bias;
		logic [12:0] bias_max;
		logic [11:0] tl_min;
		logic [11:0] tl_max;
		logic [23:0] os_win;
		logic [23:0] us_win;
		logic [2:0]  enables;
	} abt_cfg_t;

	// Input beat fields, lowest field last
	typedef struct packed {
		logic        four;
		logic        usv;
		logic [12:0] us;
		logic [12:0] os;
		logic [16:0] vspd;
		logic [8:0]  thr;
		logic [17:0] rr;
		logic [17:0] rl;
		logic [17:0] fr;
		logic [17:0] fl;
	} abt_in_t;

	typedef struct packed {
		logic        supported;
		logic [2:0]  source;
		logic [12:0] ratio;
		logic [12:0] bias;
	} abt_out_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] an;
		logic [31:0] ad;
	} abt_prep_t;

	// Classify a map value num/den and take magnitudes
	function automatic abt_prep_t ratio_prep(logic signed [31:0] num,
		logic signed [31:0] den, logic go);
		abt_prep_t r;
		r.kind = KIND_ZERO;
		r.an = num[31] ? 32'(-num) : 32'(num);
		r.ad = den[31] ? 32'(-den) : 32'(den);
		if (go) begin
			if (den == 32'sd0) begin
				if (num > 32'sd0) r.kind = KIND_FIX;
			end else if (num != 32'sd0 && (num[31] == den[31])) begin
				r.kind = KIND_DIV;
			end
		end
		return r;
	endfunction

endpackage

// ===== design/abt_front.sv =====
// Front stages: axle sums, window offsets, products and divider operands.
module abt_front import abt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  abt_cfg_t    cfg,
	input  logic        in_valid,
	input  abt_in_t     din,
	output logic        out_valid,
	output logic        out_four,
	output logic [1:0]  t_kind,
	output logic [12:0] t_fix,
	output logic [44:0] t_p,
	output logic [31:0] t_ad,
	output logic [1:0]  o_kind,
	output logic [25:0] o_p,
	output logic [12:0] o_ad,
	output logic [1:0]  u_kind,
	output logic [25:0] u_p,
	output logic [12:0] u_ad
);

	// Stage 1: axle selection and window offsets
	logic rear_c, frnt_c;
	logic signed [17:0] fl_c, fr_c, rl_c, rr_c, b0_c, b1_c, top_c;
	logic signed [18:0] ref_c;
	logic [12:0] os_abs_c;
	logic signed [13:0] os_num_c, us_num_c;
	logic signed [12:0] os_den_c, us_den_c;
	logic tr_go_c, os_go_c, us_go_c;

	assign rear_c = cfg.base_bias < Q12_HALF;
	assign frnt_c = cfg.base_bias > Q12_HALF;
	assign fl_c = $signed(din.fl);
	assign fr_c = $signed(din.fr);
	assign rl_c = $signed(din.rl);
	assign rr_c = $signed(din.rr);
	assign ref_c = rear_c ? (19'(fl_c) + 19'(fr_c)) : (19'(rl_c) + 19'(rr_c));
	assign b0_c = rear_c ? rl_c : fl_c;
	assign b1_c = rear_c ? rr_c : fr_c;
	assign top_c = (b0_c > b1_c) ? b0_c : b1_c;
	assign tr_go_c = cfg.enables[0] && (rear_c || frnt_c) && (ref_c > 19'sd512);

	assign os_abs_c = din.os[12] ? 13'(-$signed(din.os)) : din.os;
	assign os_go_c = cfg.enables[1] && (os_abs_c > {1'b0, cfg.os_win[11:0]})
		&& (din.vspd > 17'd256);
	assign os_num_c = $signed({din.os[12], din.os}) - $signed({2'b00, cfg.os_win[11:0]});
	assign os_den_c = $signed({1'b0, cfg.os_win[23:12]}) - $signed({1'b0, cfg.os_win[11:0]});

	assign us_num_c = $signed({din.us[12], din.us}) - $signed({2'b00, cfg.us_win[11:0]});
	assign us_den_c = $signed({1'b0, cfg.us_win[23:12]}) - $signed({1'b0, cfg.us_win[11:0]});
	assign us_go_c = cfg.enables[2] && din.usv
		&& ($signed({din.us[12], din.us}) > $signed({2'b00, cfg.us_win[11:0]}));

	logic vld_s1, four_s1, tr_go_s1, os_go_s1, us_go_s1;
	logic [8:0] thr_s1;
	logic signed [18:0] ref_s1;
	logic signed [17:0] b0_s1, b1_s1, top_s1;
	logic signed [13:0] os_num_s1, us_num_s1;
	logic signed [12:0] os_den_s1, us_den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			four_s1 <= din.four;
			thr_s1 <= din.thr;
			tr_go_s1 <= tr_go_c;
			os_go_s1 <= os_go_c;
			us_go_s1 <= us_go_c;
			ref_s1 <= ref_c;
			b0_s1 <= b0_c;
			b1_s1 <= b1_c;
			top_s1 <= top_c;
			os_num_s1 <= os_num_c;
			os_den_s1 <= os_den_c;
			us_num_s1 <= us_num_c;
			us_den_s1 <= us_den_c;
		end
	end

	// Stage 2: start threshold and window span of traction
	logic signed [12:0] tmin_c, dt_c;
	logic signed [31:0] a_c, tden_c;
	assign tmin_c = $signed({1'b0, cfg.tl_min});
	assign dt_c = $signed({1'b0, cfg.tl_max}) - $signed({1'b0, cfg.tl_min});
	assign a_c = ref_s1 * tmin_c;
	assign tden_c = ref_s1 * dt_c;

	logic vld_s2, four_s2, tr_go_s2, os_go_s2, us_go_s2;
	logic [8:0] thr_s2;
	logic signed [31:0] a_s2, tden_s2;
	logic signed [17:0] b0_s2, b1_s2, top_s2;
	logic signed [13:0] os_num_s2, us_num_s2;
	logic signed [12:0] os_den_s2, us_den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			four_s2 <= four_s1;
			thr_s2 <= thr_s1;
			tr_go_s2 <= tr_go_s1;
			os_go_s2 <= os_go_s1;
			us_go_s2 <= us_go_s1;
			a_s2 <= a_c;
			tden_s2 <= tden_c;
			b0_s2 <= b0_s1;
			b1_s2 <= b1_s1;
			top_s2 <= top_s1;
			os_num_s2 <= os_num_s1;
			os_den_s2 <= os_den_s1;
			us_num_s2 <= us_num_s1;
			us_den_s2 <= us_den_s1;
		end
	end

	// Stage 3: spin test and traction offset
	logic signed [31:0] b0x_c, b1x_c, topx_c, tnum_c;
	logic spin_c;
	assign b0x_c = {{5{b0_s2[17]}}, b0_s2, 9'b0};
	assign b1x_c = {{5{b1_s2[17]}}, b1_s2, 9'b0};
	assign topx_c = {{5{top_s2[17]}}, top_s2, 9'b0};
	assign spin_c = (b0x_c > a_s2) || (b1x_c > a_s2);
	assign tnum_c = topx_c - a_s2;

	logic vld_s3, four_s3, tr_go_s3, os_go_s3, us_go_s3;
	logic [8:0] thr_s3;
	logic signed [31:0] tnum_s3, tden_s3;
	logic signed [13:0] os_num_s3, us_num_s3;
	logic signed [12:0] os_den_s3, us_den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			four_s3 <= four_s2;
			thr_s3 <= thr_s2;
			tr_go_s3 <= tr_go_s2 && spin_c;
			os_go_s3 <= os_go_s2;
			us_go_s3 <= us_go_s2;
			tnum_s3 <= tnum_c;
			tden_s3 <= tden_s2;
			os_num_s3 <= os_num_s2;
			os_den_s3 <= os_den_s2;
			us_num_s3 <= us_num_s2;
			us_den_s3 <= us_den_s2;
		end
	end

	// Stage 4: classify each map and take magnitudes
	abt_prep_t tp_c, op_c, up_c;
	assign tp_c = ratio_prep(tnum_s3, tden_s3, tr_go_s3);
	assign op_c = ratio_prep(32'(os_num_s3), 32'(os_den_s3), os_go_s3);
	assign up_c = ratio_prep(32'(us_num_s3), 32'(us_den_s3), us_go_s3);

	logic vld_s4, four_s4;
	logic [8:0] thr_s4;
	logic [1:0] tk_s4, ok_s4, uk_s4;
	logic [31:0] tan_s4, tad_s4;
	logic [12:0] oan_s4, oad_s4, uan_s4, uad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			four_s4 <= four_s3;
			thr_s4 <= thr_s3;
			tk_s4 <= tp_c.kind;
			tan_s4 <= tp_c.an;
			tad_s4 <= tp_c.ad;
			ok_s4 <= op_c.kind;
			oan_s4 <= op_c.an[12:0];
			oad_s4 <= op_c.ad[12:0];
			uk_s4 <= up_c.kind;
			uan_s4 <= up_c.an[12:0];
			uad_s4 <= up_c.ad[12:0];
		end
	end

	// Stage 5: scale offsets by throttle
	logic [12:0] thr16_c, fix_c;
	logic [44:0] tp_p_c;
	logic [25:0] op_p_c, up_p_c;
	assign thr16_c = {thr_s4, 4'b0};
	assign fix_c = (thr16_c > Q12_ONE) ? Q12_ONE : thr16_c;
	assign tp_p_c = tan_s4 * thr16_c;
	assign op_p_c = oan_s4 * thr16_c;
	assign up_p_c = uan_s4 * thr16_c;

	logic vld_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (en) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_four <= four_s4;
			t_fix <= fix_c;
			t_kind <= tk_s4;
			t_p <= tp_p_c;
			t_ad <= tad_s4;
			o_kind <= ok_s4;
			o_p <= op_p_c;
			o_ad <= oad_s4;
			u_kind <= uk_s4;
			u_p <= up_p_c;
			u_ad <= uad_s4;
		end
	end

	assign out_valid = vld_s5;

endmodule

// ===== design/abt_div.sv =====
// Pipelined restoring divider giving a saturated Q1.12 ratio, or a fixed or zero ratio by kind.
module abt_div import abt_pkg::*; #(
	parameter int NW = 45,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic          in_tag,
	input  logic [1:0]    in_kind,
	input  logic [12:0]   in_fix,
	input  logic [NW-1:0] in_p,
	input  logic [DW-1:0] in_ad,
	output logic          out_valid,
	output logic          out_tag,
	output logic [12:0]   out_ratio
);

	localparam int QB = 13;
	localparam int PER = 3;
	localparam int NSTG = (QB + PER - 1) / PER;
	localparam int CW = (NW > DW + QB - 1) ? NW : DW + QB - 1;

	logic [CW-1:0] rem_s [NSTG];
	logic [12:0]   q_s [NSTG];
	logic [DW-1:0] ad_s [NSTG];
	logic [1:0]    kind_s [NSTG];
	logic [12:0]   fix_s [NSTG];
	logic          tag_s [NSTG];
	logic          vld_s [NSTG];

	for (genvar j = 0; j < NSTG; j++) begin : g_stg
		logic [CW-1:0] rem_i, rem_o;
		logic [12:0]   q_i, q_o;
		logic [DW-1:0] ad_i;
		logic [1:0]    kind_i;
		logic [12:0]   fix_i;
		logic          tag_i, vld_i;

		if (j == 0) begin : g_first
			assign rem_i = CW'(in_p);
			assign q_i = '0;
			assign ad_i = in_ad;
			assign kind_i = in_kind;
			assign fix_i = in_fix;
			assign tag_i = in_tag;
			assign vld_i = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[j-1];
			assign q_i = q_s[j-1];
			assign ad_i = ad_s[j-1];
			assign kind_i = kind_s[j-1];
			assign fix_i = fix_s[j-1];
			assign tag_i = tag_s[j-1];
			assign vld_i = vld_s[j-1];
		end

		// Resolve up to PER quotient bits, most significant first
		always_comb begin
			rem_o = rem_i;
			q_o = q_i;
			for (int i = 0; i < PER; i++) begin
				if (j * PER + i < QB) begin
					if (rem_o >= (CW'(ad_i) << (QB - 1 - j * PER - i))) begin
						rem_o = rem_o - (CW'(ad_i) << (QB - 1 - j * PER - i));
						q_o[QB - 1 - j * PER - i] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j] <= 1'b0;
			else if (en) vld_s[j] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_o;
				q_s[j] <= q_o;
				ad_s[j] <= ad_i;
				kind_s[j] <= kind_i;
				fix_s[j] <= fix_i;
				tag_s[j] <= tag_i;
			end
		end
	end

	// Select the final ratio; a top quotient bit means full transfer
	always_comb begin
		unique case (kind_s[NSTG-1])
			KIND_ZERO: out_ratio = '0;
			KIND_FIX:  out_ratio = fix_s[NSTG-1];
			KIND_DIV:  out_ratio = q_s[NSTG-1][12] ? Q12_ONE : q_s[NSTG-1];
			default:   out_ratio = '0;
		endcase
	end

	assign out_valid = vld_s[NSTG-1];
	assign out_tag = tag_s[NSTG-1];

endmodule

// ===== design/abt_back.sv =====
// Back stages: pick the largest ratio, blend the bias, clamp, output register.
module abt_back import abt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  abt_cfg_t    cfg,
	input  logic        in_valid,
	input  logic        in_four,
	input  logic [12:0] r_t,
	input  logic [12:0] r_o,
	input  logic [12:0] r_u,
	output logic        out_valid,
	output abt_out_t    dout
);

	// Stage 1: first largest positive ratio wins
	logic sup_c;
	logic [12:0] best_c;
	logic [2:0] src_c;
	assign sup_c = (cfg.base_bias != 13'd0) && (cfg.base_bias < Q12_ONE) && in_four;

	always_comb begin
		best_c = '0;
		src_c = SRC_NONE;
		if (r_t != 13'd0) begin
			best_c = r_t;
			src_c = (cfg.base_bias < Q12_HALF) ? SRC_TR_REAR : SRC_TR_FRONT;
		end
		if (r_o > best_c) begin
			best_c = r_o;
			src_c = SRC_OVER;
		end
		if (r_u > best_c) begin
			best_c = r_u;
			src_c = SRC_UNDER;
		end
		if (!sup_c) begin
			best_c = '0;
			src_c = SRC_NONE;
		end
	end

	logic vld_s1, sup_s1;
	logic [12:0] r_s1;
	logic [2:0] src_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sup_s1 <= sup_c;
			r_s1 <= best_c;
			src_s1 <= src_c;
		end
	end

	// Stage 2: blend products
	logic [12:0] inv_c;
	logic [25:0] m1_c, m2_c;
	assign inv_c = Q12_ONE - r_s1;
	assign m1_c = cfg.base_bias * inv_c;
	assign m2_c = cfg.bias_max * r_s1;

	logic vld_s2, sup_s2;
	logic [12:0] r_s2;
	logic [2:0] src_s2;
	logic [25:0] m1_s2, m2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sup_s2 <= sup_s1;
			r_s2 <= r_s1;
			src_s2 <= src_s1;
			m1_s2 <= m1_c;
			m2_s2 <= m2_c;
		end
	end

	// Stage 3: round, clamp per source
	logic [26:0] sum_c;
	logic [14:0] x_c, bias_c;
	assign sum_c = 27'(m1_s2) + 27'(m2_s2) + 27'(Q12_HALF);
	assign x_c = sum_c[26:12];

	always_comb begin
		bias_c = x_c;
		unique case (src_s2)
			SRC_NONE: bias_c = 15'(cfg.base_bias);
			SRC_TR_REAR: begin
				if (bias_c > 15'(cfg.bias_max)) bias_c = 15'(cfg.bias_max);
			end
			SRC_TR_FRONT: begin
				if (bias_c < 15'(cfg.bias_max)) bias_c = 15'(cfg.bias_max);
				if (bias_c > 15'(Q12_ONE)) bias_c = 15'(Q12_ONE);
			end
			default: begin
				if (bias_c > 15'(Q12_ONE)) bias_c = 15'(Q12_ONE);
			end
		endcase
	end

	logic vld_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.bias <= bias_c[12:0];
			dout.ratio <= r_s2;
			dout.source <= src_s2;
			dout.supported <= sup_s2;
		end
	end

	assign out_valid = vld_s3;

endmodule

// ===== design/awd_drive_bias_transfer_top.sv =====
// Top level of the four-wheel drive front bias transfer pipeline.
// One control tick per input beat yields one result beat. The block takes a
// beat every cycle unless the output stalls, passing it through five front
// stages (axle sums, threshold products, offsets, operand prep, throttle
// scaling), three parallel five-stage restoring dividers resolving up to
// three quotient bits per stage, and three back stages (ratio pick, blend
// products, rounding and clamp into the output register). A stalled output
// holds the whole pipe, so s_tready is low only while a result waits and
// m_tready is low. Configuration is written through the cfg port and is
// registered on a clock edge where cfg_we is high.
module awd_drive_bias_transfer_top import abt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [23:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// fl[17:0] fr[35:18] rl[53:36] rr[71:54] throttle[80:72] vehicle_speed[97:81]
	// oversteer_angle[110:98] understeer_angle[123:111] understeer_valid[124]
	// four_wheels[125] zero[127:126]
	input  logic [127:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bias_front[12:0] transfer_ratio[25:13] source[28:26] supported[29] zero[31:30]
	output logic [31:0]  m_tdata
);

	abt_cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_bias <= 13'd2048;
			cfg_q.bias_max <= 13'd2048;
			cfg_q.tl_min <= 12'd281;
			cfg_q.tl_max <= 12'd512;
			cfg_q.os_win <= '0;
			cfg_q.us_win <= '0;
			cfg_q.enables <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_BASE_BIAS: cfg_q.base_bias <= cfg_wdata[12:0];
				CFG_BIAS_MAX:  cfg_q.bias_max <= cfg_wdata[12:0];
				CFG_TL_MIN:    cfg_q.tl_min <= cfg_wdata[11:0];
				CFG_TL_MAX:    cfg_q.tl_max <= cfg_wdata[11:0];
				CFG_OS_WINDOW: cfg_q.os_win <= cfg_wdata;
				CFG_US_WINDOW: cfg_q.us_win <= cfg_wdata;
				CFG_ENABLES:   cfg_q.enables <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Advance the whole pipe unless a result is held
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	abt_in_t din;
	assign din = s_tdata[125:0];

	logic f_valid, f_four;
	logic [1:0] t_kind, o_kind, u_kind;
	logic [12:0] t_fix, o_ad, u_ad;
	logic [44:0] t_p;
	logic [31:0] t_ad;
	logic [25:0] o_p, u_p;

	abt_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(s_tvalid), .din(din),
		.out_valid(f_valid), .out_four(f_four),
		.t_kind(t_kind), .t_fix(t_fix), .t_p(t_p), .t_ad(t_ad),
		.o_kind(o_kind), .o_p(o_p), .o_ad(o_ad),
		.u_kind(u_kind), .u_p(u_p), .u_ad(u_ad)
	);

	logic d_valid, d_four;
	logic [12:0] r_t, r_o, r_u;

	abt_div #(.NW(45), .DW(32)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .in_tag(f_four), .in_kind(t_kind), .in_fix(t_fix),
		.in_p(t_p), .in_ad(t_ad),
		.out_valid(d_valid), .out_tag(d_four), .out_ratio(r_t)
	);

	abt_div #(.NW(26), .DW(13)) u_div_o (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .in_tag(1'b0), .in_kind(o_kind), .in_fix(t_fix),
		.in_p(o_p), .in_ad(o_ad),
		.out_valid(), .out_tag(), .out_ratio(r_o)
	);

	abt_div #(.NW(26), .DW(13)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(f_valid), .in_tag(1'b0), .in_kind(u_kind), .in_fix(t_fix),
		.in_p(u_p), .in_ad(u_ad),
		.out_valid(), .out_tag(), .out_ratio(r_u)
	);

	abt_out_t dout;

	abt_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(d_valid), .in_four(d_four),
		.r_t(r_t), .r_o(r_o), .r_u(r_u),
		.out_valid(m_tvalid), .dout(dout)
	);

	assign m_tdata = {2'b00, dout};

	// Unsupported results carry no transfer
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !dout.supported |-> dout.source == SRC_NONE && dout.ratio == 13'd0)
		else $error("unsupported result carries a transfer");

	// A named source always has a positive ratio, and none has no ratio
	a_src_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((dout.source == SRC_NONE) == (dout.ratio == 13'd0)))
		else $error("source and ratio disagree");

	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> dout.ratio <= Q12_ONE)
		else $error("ratio above one");

	a_src_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> dout.source <= SRC_UNDER)
		else $error("undefined source code");

endmodule
